// ===== rtl/rt_pkg.sv =====
// Package with the residue types and fixed constants of the primitive root test.
`default_nettype none

package rt_pkg;

    // Width of a residue modulo the prime and of the candidate field.
    localparam int RES_W  = 31;
    localparam int CAND_W = 31;
    localparam int PROD_W = 2 * RES_W;

    // Width of the exponents; the largest one, (p-1)/2, fits in 30 bits.
    localparam int EXP_W  = 30;

    // The prime 2^30 + 2^13 + 1.
    localparam logic [RES_W-1:0] PRIME = 31'h4000_2001;

    // Exponents (p-1)/2, (p-1)/3 and (p-1)/43691.
    localparam logic [EXP_W-1:0] EXP_A = 30'h2000_1000;
    localparam logic [EXP_W-1:0] EXP_B = 30'h1555_6000;
    localparam logic [EXP_W-1:0] EXP_C = 30'h0000_6000;

    // One cell per exponent bit.
    localparam int NUM_CELLS = EXP_W;
    localparam int NUM_EXP   = 3;

    typedef logic [RES_W-1:0] t_residue;
    typedef t_residue [NUM_EXP-1:0] t_acc_set;

endpackage

`default_nettype wire

// ===== rtl/rt_if.sv =====
// Handshake interfaces for the candidate and result channels.
`default_nettype none

interface rt_cand_if;
    logic        valid;
    logic        ready;
    logic [30:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface rt_res_if;
    logic valid;
    logic ready;
    logic is_generator;

    modport source (output valid, output is_generator, input ready);
    modport sink   (input valid, input is_generator, output ready);
endinterface

`default_nettype wire

// ===== rtl/primitive_root_test_top.sv =====
// Top level of the primitive root test: input register, chain of exponent cells, output skid.
//
//   Channel  Direction  Payload                Accepted when
//   i_cand   in         candidate [30:0]       valid && ready
//   o_res    out        is_generator [0:0]     valid && ready
//
// One item is taken per cycle while ready is high; ready drops only while the skid register is full.
// The path runs through 30 cells of three multiplier stages each, plus input and output registers.
// Reset clears every valid bit; no item is lost or repeated across a stall.
// A waiting result sits in the output register while a second one may park in the skid
// register; only a full skid register stops the chain and drops ready.
`default_nettype none

module primitive_root_test_top
    import rt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rt_cand_if.sink    i_cand,
    rt_res_if.source   o_res
);

    logic                   en;
    logic                   pop;
    logic                   r_in_valid;
    t_residue               r_in_x;
    t_residue               n_in_x;
    logic [NUM_CELLS:0]     chain_valid;
    t_residue [NUM_CELLS:0] chain_sq;
    t_acc_set [NUM_CELLS:0] chain_acc;
    logic                   last_gen;
    logic                   r_out_valid;
    logic                   r_out_gen;
    logic                   r_skid_valid;
    logic                   r_skid_gen;

    // The chain moves unless the skid register holds an item.
    assign en           = !r_skid_valid;
    assign pop          = r_out_valid && o_res.ready;
    assign i_cand.ready = en;

    // A 31-bit candidate is below twice the prime, so one subtraction reduces it.
    always_comb begin
        if (i_cand.candidate >= PRIME) begin
            n_in_x = i_cand.candidate - PRIME;
        end else begin
            n_in_x = i_cand.candidate;
        end
    end

    // Input register feeding the first cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_cand.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_x <= n_in_x;
        end
    end

    assign chain_valid[0] = r_in_valid;
    assign chain_sq[0]    = r_in_x;
    assign chain_acc[0]   = {NUM_EXP{t_residue'(1)}};

    // One cell per exponent bit, least significant first.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        rt_cell #(
            .MUL_SEL ({EXP_C[k], EXP_B[k], EXP_A[k]})
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (chain_valid[k]),
            .i_sq    (chain_sq[k]),
            .i_acc   (chain_acc[k]),
            .o_valid (chain_valid[k+1]),
            .o_sq    (chain_sq[k+1]),
            .o_acc   (chain_acc[k+1])
        );
    end

    // Generator only if every power is above one.
    always_comb begin
        last_gen = 1'b1;
        for (int i = 0; i < NUM_EXP; i++) begin
            if (chain_acc[NUM_CELLS][i] <= t_residue'(1)) begin
                last_gen = 1'b0;
            end
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_gen    <= r_skid_gen;
                r_skid_valid <= 1'b0;
            end
        end else if (chain_valid[NUM_CELLS]) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
                r_out_gen   <= last_gen;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_gen   <= last_gen;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.is_generator = r_out_gen;

endmodule

`default_nettype wire

// ===== rtl/rt_modmul.sv =====
// Three-stage pipelined multiplier modulo the prime 2^30 + 2^13 + 1.
`default_nettype none

module rt_modmul
    import rt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  wire t_residue i_a,
    input  wire t_residue i_b,
    output t_residue      o_r
);

    logic [PROD_W-1:0]       r_prod;
    logic signed [44:0]      r_fold;
    logic signed [44:0]      n_fold;
    logic [14:0]             n_neg;
    logic [13:0]             n_u;
    logic [RES_W-1:0]        n_sum;
    t_residue                r_res;
    t_residue                n_res;

    // First fold: 2^30 is congruent to -(2^13 + 1), so high*2^30 + low maps to
    // low - high*(2^13+1). The high part has 32 bits and its top bit is always clear.
    always_comb begin
        n_fold = $signed({15'b0, r_prod[29:0]})
               - $signed({13'b0, r_prod[PROD_W-1:30]})
               - $signed({r_prod[PROD_W-1:30], 13'b0});
    end

    // Second fold: the upper part is small and non-positive, so its magnitude is added back.
    always_comb begin
        n_neg = 15'd0 - r_fold[44:30];
        n_u   = n_neg[13:0];
        n_sum = {1'b0, r_fold[29:0]} + {17'b0, n_u} + {4'b0, n_u, 13'b0};
        if (n_sum >= PRIME) begin
            n_res = n_sum - PRIME;
        end else begin
            n_res = n_sum;
        end
    end

    // Product, first fold and final residue each sit in a register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
            r_fold <= n_fold;
            r_res  <= n_res;
        end
    end

    assign o_r = r_res;

endmodule

`default_nettype wire

// ===== rtl/rt_cell.sv =====
// One exponent bit: squares the running power and multiplies it into the accumulators whose bit is set.
`default_nettype none

module rt_cell
    import rt_pkg::*;
#(
    parameter logic [NUM_EXP-1:0] MUL_SEL = 3'b000
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire t_residue i_sq,
    input  wire t_acc_set i_acc,
    output logic          o_valid,
    output t_residue      o_sq,
    output t_acc_set      o_acc
);

    logic [2:0] r_valid;

    // Valid bits follow the three multiplier stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    assign o_valid = r_valid[2];

    // The running power is squared for the next bit.
    rt_modmul u_sq (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_sq),
        .i_b   (i_sq),
        .o_r   (o_sq)
    );

    // Each accumulator either multiplies or passes through three delay registers that match the multiplier stages.
    for (genvar g = 0; g < NUM_EXP; g++) begin : g_acc
        if (MUL_SEL[g]) begin : g_mul
            rt_modmul u_mul (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_a   (i_acc[g]),
                .i_b   (i_sq),
                .o_r   (o_acc[g])
            );
        end else begin : g_dly
            t_residue r_d0, r_d1, r_d2;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d0 <= i_acc[g];
                    r_d1 <= r_d0;
                    r_d2 <= r_d1;
                end
            end
            assign o_acc[g] = r_d2;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rt_checker.sv =====
// Port-level checker for the primitive root test, bound to the top level.
`default_nettype none

module rt_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_gen
);

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Input backpressure only appears while a result is waiting.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

    // Ready only drops after a result was refused.
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_out_valid && !i_out_ready))
        else $error("ready dropped without a refused result");

    // A refused result holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_gen))
        else $error("result changed while stalled");

    // The input valid is always driven to a known level out of reset.
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(i_in_valid))
        else $error("input valid unknown");

endmodule

bind primitive_root_test_top rt_checker u_rt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cand.valid),
    .i_in_ready  (i_cand.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_gen   (o_res.is_generator)
);

`default_nettype wire
